FILE: design/delta_copy_literal_emitter_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delta command emitter
// Shared macros for the concurrent checks of the emitter's port behavior.
// ----------------------------------------------------------------------------
`ifndef DELTA_COPY_LITERAL_EMITTER_UNIT_ASSERT_SVH
`define DELTA_COPY_LITERAL_EMITTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked only while out of reset.
`define DCLE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only while out of reset.
`define DCLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/dcle_pkg.sv
// ----------------------------------------------------------------------------
// Delta command emitter package
// Request and command codes, the push control group and queue sizing.
// ----------------------------------------------------------------------------
package dcle_pkg;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] REQ_MATCH   = 2'd0;
  localparam logic [1:0] REQ_NOMATCH = 2'd1;
  localparam logic [1:0] REQ_END     = 2'd2;

  // Command kinds carried on the output tuser.
  localparam logic KIND_LITERAL = 1'b0;
  localparam logic KIND_COPY    = 1'b1;

  // Depth of the command queue; a power of two.
  localparam int CMD_FIFO_DEPTH = 4;

  // Push control from the command generator to the queue.
  typedef struct packed {
    logic push_a;
    logic push_b;
  } dcle_push_t;

endpackage

FILE: design/delta_copy_literal_emitter_unit.sv
// Path: a request waits in the input register until the queue has room, then its commands
// enter the queue. Throughput: one request per cycle while each yields at most one command
// and the output is ready; the single result channel drains the queue one command at a time.
// Reset: synchronous, active low; clears the write position, pending copy, file size
// register and the command queue.
// ----------------------------------------------------------------------------
// Delta copy/literal command emitter
// Turns sorted matched chunk pairs into copy and literal commands, merging
// copies whose old-file ranges are contiguous.
// ----------------------------------------------------------------------------
module delta_copy_literal_emitter_unit #(
  parameter int OFFSET_BITS = 48
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input channel.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // Fields from bit 0: new_offset, new_length, old_offset, old_length.
  input  logic [((4*OFFSET_BITS+7)/8)*8-1:0]     in_tdata,
  // Fields from bit 0: req_type.
  input  logic [1:0]                             in_tuser,
  // Result channel.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // Fields from bit 0: cmd_offset, cmd_length.
  output logic [((2*OFFSET_BITS+7)/8)*8-1:0]     out_tdata,
  // Fields from bit 0: cmd_kind.
  output logic                                   out_tuser,
  output logic                                   out_tlast,
  // Configuration port.
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [3:0]                             cfg_paddr,
  input  logic [63:0]                            cfg_pwdata,
  output logic [63:0]                            cfg_prdata,
  output logic                                   cfg_pready
);
  import dcle_pkg::*;

  localparam int OUT_TDATA_W = ((2*OFFSET_BITS+7)/8)*8;
  localparam int CMD_W       = 2*OFFSET_BITS + 2;

  logic                   in_valid_r;
  logic [1:0]             req_type_r;
  logic [OFFSET_BITS-1:0] new_offset_r;
  logic [OFFSET_BITS-1:0] new_length_r;
  logic [OFFSET_BITS-1:0] old_offset_r;
  logic [OFFSET_BITS-1:0] old_length_r;
  logic [OFFSET_BITS-1:0] total_size_r;

  logic                   fire;
  logic                   room;
  dcle_push_t             push;
  dcle_push_t             push_gated;
  logic [CMD_W-1:0]       cmd_a;
  logic [CMD_W-1:0]       cmd_b;
  logic [CMD_W-1:0]       cmd_out;
  logic                   cfg_wr;

  // Configuration register; registers sit on 8-byte words.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[3] == 1'b0) ? 64'(total_size_r) : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_size_r <= '0;
    end else if (cfg_wr && (cfg_paddr[3] == 1'b0)) begin
      total_size_r <= cfg_pwdata[OFFSET_BITS-1:0];
    end
  end

  // Input register: a request is processed once the queue has room for two.
  assign fire      = in_valid_r && room;
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_type_r   <= in_tuser;
      new_offset_r <= in_tdata[OFFSET_BITS-1:0];
      new_length_r <= in_tdata[2*OFFSET_BITS-1:OFFSET_BITS];
      old_offset_r <= in_tdata[3*OFFSET_BITS-1:2*OFFSET_BITS];
      old_length_r <= in_tdata[4*OFFSET_BITS-1:3*OFFSET_BITS];
    end
  end

  // Command generation and state.
  dcle_core #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .req_type   (req_type_r),
    .new_offset (new_offset_r),
    .new_length (new_length_r),
    .old_offset (old_offset_r),
    .old_length (old_length_r),
    .total_size (total_size_r),
    .push       (push),
    .cmd_a      (cmd_a),
    .cmd_b      (cmd_b)
  );

  // Commands enter the queue only for a processed request.
  always_comb begin
    push_gated.push_a = push.push_a && fire;
    push_gated.push_b = push.push_b && fire;
  end

  dcle_cmd_fifo #(
    .DATA_W(CMD_W)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_gated),
    .din_a      (cmd_a),
    .din_b      (cmd_b),
    .room       (room),
    .dout_valid (out_tvalid),
    .dout_ready (out_tready),
    .dout       (cmd_out)
  );

  // Unpack the head command onto the result channel.
  assign out_tdata = OUT_TDATA_W'(cmd_out[2*OFFSET_BITS-1:0]);
  assign out_tuser = cmd_out[2*OFFSET_BITS];
  assign out_tlast = cmd_out[2*OFFSET_BITS+1];

endmodule

FILE: design/dcle_core.sv
// ----------------------------------------------------------------------------
// Delta command generator
// Holds the write position and pending copy, and turns one request into up
// to two commands in a single cycle.
// ----------------------------------------------------------------------------
module dcle_core #(
  parameter int OFFSET_BITS = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     fire,
  input  logic [1:0]               req_type,
  input  logic [OFFSET_BITS-1:0]   new_offset,
  input  logic [OFFSET_BITS-1:0]   new_length,
  input  logic [OFFSET_BITS-1:0]   old_offset,
  input  logic [OFFSET_BITS-1:0]   old_length,
  input  logic [OFFSET_BITS-1:0]   total_size,
  output dcle_pkg::dcle_push_t     push,
  // Command word, lowest bit up: offset, length, kind, last.
  output logic [2*OFFSET_BITS+1:0] cmd_a,
  output logic [2*OFFSET_BITS+1:0] cmd_b
);
  import dcle_pkg::*;

  logic [OFFSET_BITS-1:0] wp_r, wp_nxt;
  logic [OFFSET_BITS-1:0] ps_r, ps_nxt;
  logic [OFFSET_BITS-1:0] pl_r, pl_nxt;

  logic                   gap;
  logic                   pl_zero;
  logic                   merge_ok;
  logic [OFFSET_BITS-1:0] lit_end;
  logic [OFFSET_BITS-1:0] lit_len;
  logic                   copy_v;
  logic                   lit_v;

  // Shared arithmetic for all request kinds.
  assign gap      = new_offset > wp_r;
  assign pl_zero  = (pl_r == '0);
  assign merge_ok = pl_zero || (old_offset == ps_r + pl_r);
  assign lit_end  = (req_type == REQ_MATCH) ? new_offset : total_size;
  assign lit_len  = lit_end - wp_r;

  // Candidate commands and next state per request kind.
  always_comb begin
    copy_v = 1'b0;
    lit_v  = 1'b0;
    wp_nxt = wp_r;
    ps_nxt = ps_r;
    pl_nxt = pl_r;
    case (req_type)
      REQ_MATCH: begin
        wp_nxt = (gap ? new_offset : wp_r) + new_length;
        if (gap) begin
          copy_v = !pl_zero;
          lit_v  = 1'b1;
          ps_nxt = old_offset;
          pl_nxt = old_length;
        end else if (merge_ok) begin
          ps_nxt = pl_zero ? old_offset : ps_r;
          pl_nxt = pl_r + old_length;
        end else begin
          copy_v = 1'b1;
          ps_nxt = old_offset;
          pl_nxt = old_length;
        end
      end
      REQ_NOMATCH: begin
        lit_v  = 1'b1;
        wp_nxt = total_size;
      end
      REQ_END: begin
        copy_v = !pl_zero;
        lit_v  = wp_r < total_size;
        wp_nxt = '0;
        ps_nxt = '0;
        pl_nxt = '0;
      end
      default: begin
        copy_v = 1'b0;
      end
    endcase
  end

  // Order the commands: a pending copy always goes before the literal.
  always_comb begin
    push.push_a = copy_v | lit_v;
    push.push_b = copy_v & lit_v;
    if (copy_v) begin
      cmd_a = {!lit_v, KIND_COPY, pl_r, ps_r};
    end else begin
      cmd_a = {1'b1, KIND_LITERAL, lit_len, wp_r};
    end
    cmd_b = {1'b1, KIND_LITERAL, lit_len, wp_r};
  end

  // State registers, updated when a request is processed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      ps_r <= '0;
      pl_r <= '0;
    end else if (fire) begin
      wp_r <= wp_nxt;
      ps_r <= ps_nxt;
      pl_r <= pl_nxt;
    end
  end

endmodule

FILE: design/dcle_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Small register queue that takes up to two commands per cycle and hands
// out one per cycle on the result channel while the receiver is ready.
// ----------------------------------------------------------------------------
module dcle_cmd_fifo #(
  parameter int DATA_W = 98
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dcle_pkg::dcle_push_t push,
  input  logic [DATA_W-1:0]    din_a,
  input  logic [DATA_W-1:0]    din_b,
  output logic                 room,
  output logic                 dout_valid,
  input  logic                 dout_ready,
  output logic [DATA_W-1:0]    dout
);
  import dcle_pkg::*;

  localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
  localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

  logic [DATA_W-1:0] mem_r [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pop;

  assign pop        = dout_valid && dout_ready;
  assign dout_valid = (count_r != '0);
  assign dout       = mem_r[rd_ptr_r];
  // Room for two more commands, whatever leaves this cycle.
  assign room       = (count_r <= CNT_W'(CMD_FIFO_DEPTH - 2));

  // Pointer and fill count arithmetic.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.push_a) + PTR_W'(push.push_b);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push.push_a) + CNT_W'(push.push_b) - CNT_W'(pop);
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.push_a) begin
      mem_r[wr_ptr_r] <= din_a;
    end
    if (push.push_b) begin
      mem_r[wr_ptr_r + PTR_W'(1)] <= din_b;
    end
  end

  // Queue control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: design/dcle_checker.sv
// ----------------------------------------------------------------------------
// Delta command emitter port checker
// Concurrent checks on the emitter's ports, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "delta_copy_literal_emitter_unit_assert.svh"

module dcle_checker #(
  parameter int OFFSET_BITS = 48
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [((2*OFFSET_BITS+7)/8)*8-1:0] out_tdata,
  input logic                               out_tuser,
  input logic                               out_tlast
);
  import dcle_pkg::*;

  // A stalled command keeps its contents.
  `DCLE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled command changed")

  // A copy never covers zero bytes: empty pending copies are never flushed.
  `DCLE_ASSERT_NOW(a_copy_nonzero, clk, rst_n, out_tvalid && (out_tuser == KIND_COPY), out_tdata[2*OFFSET_BITS-1:OFFSET_BITS] != '0, "copy command of zero length")

  // The second command of a pair is queued together with the first.
  `DCLE_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid, "second command of a pair missing")

  // With the result queue empty the input side is never stalled.
  `DCLE_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready, "input stalled with empty queue")

endmodule

bind delta_copy_literal_emitter_unit dcle_checker #(.OFFSET_BITS(OFFSET_BITS)) u_dcle_checker (.*);

FILE: test/delta_copy_literal_emitter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta command emitter testbench
// Drives sorted chunk matches, no-match markers and end-of-stream requests
// into the emitter under several file sizes. A behavioral copy of the command
// generator predicts every copy and literal command, and each command that
// leaves the block is checked against the oldest prediction. Both stream
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module delta_copy_literal_emitter_unit_tb;
  import dcle_pkg::*;

  localparam logic [1:0]  REQ_UNUSED      = 2'd3;
  localparam logic [3:0]  ADDR_TOTAL_SIZE = 4'h0;
  localparam logic [47:0] OFFSET_MAX      = 48'hFFFF_FFFF_FFFF;
  localparam int          DRAIN_SLACK     = 6;
  localparam int          WATCHDOG_LIMIT  = 4000;

  typedef struct {
    logic [1:0]  req_type;
    logic [47:0] new_offset;
    logic [47:0] new_length;
    logic [47:0] old_offset;
    logic [47:0] old_length;
  } chunk_req_t;

  typedef struct {
    logic        kind;
    logic [47:0] offset;
    logic [47:0] length;
    logic        is_last;
  } delta_cmd_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // Fields from bit 0: new_offset, new_length, old_offset, old_length.
  logic [191:0] in_tdata = '0;
  // Fields from bit 0: req_type.
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // Fields from bit 0: cmd_offset, cmd_length.
  logic [95:0]  out_tdata;
  // Fields from bit 0: cmd_kind.
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [3:0]   cfg_paddr = '0;
  logic [63:0]  cfg_pwdata = '0;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  // Predictor state: configured size, covered position and the pending copy.
  logic [47:0]  total_size = '0;
  logic [47:0]  fill_pos = '0;
  logic [47:0]  run_start = '0;
  logic [47:0]  run_len = '0;

  delta_cmd_t   expected_cmds[$];
  delta_cmd_t   head_cmd;
  int           fail_count = 0;
  int           burst_left = 4;
  int           stall_mode = 0;
  int           stall_mode_left = 0;
  int           idle_cycles = 0;
  int unsigned  cycle_count = 0;

  delta_copy_literal_emitter_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic chunk_req_t mk_req(input logic [1:0] t, input logic [47:0] no,
                                        input logic [47:0] nl, input logic [47:0] oo,
                                        input logic [47:0] ol);
    chunk_req_t r;
    r.req_type   = t;
    r.new_offset = no;
    r.new_length = nl;
    r.old_offset = oo;
    r.old_length = ol;
    return r;
  endfunction

  function automatic delta_cmd_t mk_cmd(input logic k, input logic [47:0] off,
                                        input logic [47:0] len);
    delta_cmd_t c;
    c.kind    = k;
    c.offset  = off;
    c.length  = len;
    c.is_last = 1'b0;
    return c;
  endfunction

  // Works out the commands one request causes and updates the predictor state.
  task automatic predict_commands(input chunk_req_t r);
    delta_cmd_t cmds[$];
    delta_cmd_t c;
    case (r.req_type)
      REQ_MATCH: begin
        // A gap before the chunk flushes the pending copy and becomes a literal.
        if (r.new_offset > fill_pos) begin
          if (run_len != 0) begin
            cmds.insert(cmds.size(), mk_cmd(KIND_COPY, run_start, run_len));
            run_len = '0;
          end
          cmds.insert(cmds.size(), mk_cmd(KIND_LITERAL, fill_pos, r.new_offset - fill_pos));
          fill_pos  = r.new_offset;
          run_start = r.old_offset;
        end
        if (run_len == 0) run_start = r.old_offset;
        // Contiguous old-file ranges merge; anything else restarts the copy.
        if (r.old_offset == 48'(run_start + run_len)) begin
          run_len = run_len + r.old_length;
        end else begin
          cmds.insert(cmds.size(), mk_cmd(KIND_COPY, run_start, run_len));
          run_start = r.old_offset;
          run_len   = r.old_length;
        end
        fill_pos = fill_pos + r.new_length;
      end
      REQ_NOMATCH: begin
        cmds.insert(cmds.size(), mk_cmd(KIND_LITERAL, fill_pos, total_size - fill_pos));
        fill_pos = total_size;
      end
      REQ_END: begin
        if (run_len != 0) cmds.insert(cmds.size(), mk_cmd(KIND_COPY, run_start, run_len));
        if (fill_pos < total_size)
          cmds.insert(cmds.size(), mk_cmd(KIND_LITERAL, fill_pos, total_size - fill_pos));
        fill_pos  = '0;
        run_start = '0;
        run_len   = '0;
      end
      default: ;
    endcase
    foreach (cmds[i]) begin
      c = cmds[i];
      c.is_last = (i == cmds.size() - 1);
      expected_cmds.insert(expected_cmds.size(), c);
    end
  endtask

  // Sends one request, waits for its transaction and runs the sender's bursts.
  task automatic send_req(input chunk_req_t r);
    in_tvalid <= 1'b1;
    in_tuser  <= r.req_type;
    in_tdata  <= {r.old_length, r.old_offset, r.new_length, r.new_offset};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_commands(r);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
    end
  endtask

  // Holds the sender off until every predicted command has arrived.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Writes the file size register while idle, then reads it back.
  task automatic write_file_size(input logic [47:0] size);
    wait_idle();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= ADDR_TOTAL_SIZE;
    cfg_pwdata  <= {16'h0, size};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    total_size = size;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[47:0] !== size) begin
      $error("new_file_size: expected %0h, actual %0h", size, cfg_prdata[47:0]);
      fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // An end of stream with nothing pending, and a no-match marker at size zero.
  task automatic test_empty_stream();
    write_file_size('0);
    send_req(mk_req(REQ_END, '0, '0, '0, '0));
    send_req(mk_req(REQ_NOMATCH, '0, '0, '0, '0));
    send_req(mk_req(REQ_END, '0, '0, '0, '0));
  endtask

  // Copy merging, gap literals, overlapping and backward chunks, final flush.
  task automatic test_merge_and_gap();
    write_file_size(48'd1000);
    send_req(mk_req(REQ_MATCH, 48'd0,   48'd100, 48'd500, 48'd100));
    send_req(mk_req(REQ_MATCH, 48'd100, 48'd50,  48'd600, 48'd50));
    send_req(mk_req(REQ_MATCH, 48'd200, 48'd10,  48'd50,  48'd10));
    // The sender waits here until all commands so far have come out.
    wait_idle();
    send_req(mk_req(REQ_MATCH, 48'd210, 48'd10,  48'd60,  48'd10));
    send_req(mk_req(REQ_MATCH, 48'd215, 48'd10,  48'd900, 48'd10));
    send_req(mk_req(REQ_MATCH, 48'd100, 48'd5,   48'd910, 48'd5));
    send_req(mk_req(REQ_NOMATCH, '0, '0, '0, '0));
    send_req(mk_req(REQ_END, '0, '0, '0, '0));
    send_req(mk_req(REQ_END, '0, '0, '0, '0));
  endtask

  // Zero-length chunk, a chunk past the file end, a wrapped literal length,
  // and an unused request kind that must be ignored.
  task automatic test_corner_requests();
    send_req(mk_req(REQ_MATCH, '0, '0, '0, '0));
    send_req(mk_req(REQ_NOMATCH, '0, '0, '0, '0));
    send_req(mk_req(REQ_MATCH, 48'd2000, 48'd30, 48'd7, 48'd30));
    send_req(mk_req(REQ_NOMATCH, '0, '0, '0, '0));
    send_req(mk_req(REQ_UNUSED, OFFSET_MAX, OFFSET_MAX, OFFSET_MAX, OFFSET_MAX));
    send_req(mk_req(REQ_END, '0, '0, '0, '0));
  endtask

  // All-ones fields, wrapping positions and a merged copy that wraps to zero.
  task automatic test_wrap_extremes();
    write_file_size(OFFSET_MAX);
    send_req(mk_req(REQ_END, '0, '0, '0, '0));
    send_req(mk_req(REQ_MATCH, OFFSET_MAX, OFFSET_MAX, OFFSET_MAX, OFFSET_MAX));
    send_req(mk_req(REQ_MATCH, '0, 48'd1, OFFSET_MAX - 48'd1, 48'd1));
    send_req(mk_req(REQ_NOMATCH, '0, '0, '0, '0));
    send_req(mk_req(REQ_END, '0, '0, '0, '0));
  endtask

  // Random streams: mostly ordered matches that follow the covered position,
  // with markers, end items, ignored kinds and fully random noise mixed in.
  task automatic run_stream_phase(input logic [47:0] size, input int n_items);
    chunk_req_t r;
    int         roll;
    int         sent;
    sent = 0;
    write_file_size(size);
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      r = mk_req(REQ_MATCH, rand48(), rand48(), rand48(), rand48());
      if (roll < 74) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: r.new_offset = fill_pos;
          12, 13, 14, 15, 16: r.new_offset = fill_pos + 48'($urandom_range(1, 512));
          17, 18: r.new_offset = fill_pos - 48'($urandom_range(0, 256));
          default: ;
        endcase
        case ($urandom_range(0, 19))
          0: r.new_length = '0;
          1, 2: ;
          default: r.new_length = 48'($urandom_range(1, 4096));
        endcase
        case ($urandom_range(0, 3))
          0, 1: r.old_offset = run_start + run_len;
          2: r.old_offset = 48'($urandom_range(0, 1 << 20));
          default: ;
        endcase
        if ($urandom_range(0, 4) != 0) r.old_length = r.new_length;
        else if ($urandom_range(0, 1) != 0) r.old_length = 48'($urandom_range(0, 4096));
      end else if (roll < 82) begin
        r.req_type = REQ_NOMATCH;
      end else if (roll < 89) begin
        r.req_type = REQ_END;
      end else if (roll < 92) begin
        r.req_type = REQ_UNUSED;
      end else begin
        r.req_type = 2'($urandom_range(0, 2));
      end
      if ($urandom_range(0, 99) == 0) wait_idle();
      send_req(r);
      if (r.req_type != REQ_UNUSED) sent++;
    end
  endtask

  // Receiver stalls follow a mode that is chosen anew at random whenever its hold count runs out.
  always @(posedge clk) begin
    cycle_count++;
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(16, 128);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (cycle_count[3:0] > 4'd10);
    endcase
  end

  // Compares every command transaction with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_cmds.size() == 0) begin
        $error("unexpected command: kind %0d offset %0h length %0h",
               out_tuser, out_tdata[47:0], out_tdata[95:48]);
        fail_count++;
      end else begin
        head_cmd = expected_cmds.pop_front();
        if (out_tuser !== head_cmd.kind) begin
          $error("cmd_kind: expected %0d, actual %0d", head_cmd.kind, out_tuser);
          fail_count++;
        end
        if (out_tdata[47:0] !== head_cmd.offset) begin
          $error("cmd_offset: expected %0h, actual %0h", head_cmd.offset, out_tdata[47:0]);
          fail_count++;
        end
        if (out_tdata[95:48] !== head_cmd.length) begin
          $error("cmd_length: expected %0h, actual %0h", head_cmd.length, out_tdata[95:48]);
          fail_count++;
        end
        if (out_tlast !== head_cmd.is_last) begin
          $error("last: expected %0d, actual %0d", head_cmd.is_last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // Ends the run when no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_stream();
    test_merge_and_gap();
    test_corner_requests();
    test_wrap_extremes();
    run_stream_phase('0, 120);
    run_stream_phase(48'($urandom_range(1, 1 << 16)), 200);
    run_stream_phase(OFFSET_MAX, 120);
    run_stream_phase(rand48(), 120);
    run_stream_phase(48'($urandom_range(1, 4096)), 200);
    run_stream_phase(48'd1, 140);
    wait_idle();
    repeat (DRAIN_SLACK) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

FILE: files.f
+incdir+design
design/dcle_pkg.sv
design/dcle_core.sv
design/dcle_cmd_fifo.sv
design/delta_copy_literal_emitter_unit.sv
design/dcle_checker.sv
test/delta_copy_literal_emitter_unit_tb.sv
